### hdl/rts_pkg.sv
// ---------------------------------------------------------------------------
// rts_pkg: shared types and constants for the RTOS task scheduler.
// Holds the request and result item layouts, request codes, task states
// and the default sizes handed to the top level.
// ---------------------------------------------------------------------------
package rts_pkg;

    localparam int MAX_TASKS  = 8;
    localparam int DELAY_BITS = 32;

    // Request codes.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_DELAY = 2'd1;
    localparam logic [1:0] REQ_BLOCK = 2'd2;
    localparam logic [1:0] REQ_WAKE  = 2'd3;

    // Task states.
    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_BLOCK = 2'd2;

    // Configuration register index.
    localparam logic REG_TASK_COUNT = 1'b0;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] delay_ticks;
        logic        queue_side;
    } req_t;

    typedef struct packed {
        logic [2:0] next_task;
        logic       idle_chosen;
        logic       task_found;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_APPLY = 4'b0010,
        S_TICK  = 4'b0100,
        S_SEL   = 4'b1000
    } state_t;

endpackage

### hdl/rts_delay_mem.sv
// ---------------------------------------------------------------------------
// rts_delay_mem: delay counter store.
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module rts_delay_mem #(
    parameter int MAX_TASKS  = rts_pkg::MAX_TASKS,
    parameter int DELAY_BITS = rts_pkg::DELAY_BITS
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(MAX_TASKS)-1:0] waddr,
    input  logic [DELAY_BITS-1:0]        wdata,
    input  logic [$clog2(MAX_TASKS)-1:0] raddr,
    output logic [DELAY_BITS-1:0]        rdata
);

    logic [DELAY_BITS-1:0] mem [MAX_TASKS];
    logic [DELAY_BITS-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/rts_select.sv
// ---------------------------------------------------------------------------
// rts_select: next task choice.
// Marks skipped blocked tasks as owed, serves the lowest owed ready task,
// otherwise the next ready task after the last index with wrap; the idle slot if all are blocked.
// ---------------------------------------------------------------------------
module rts_select #(
    parameter int MAX_TASKS = rts_pkg::MAX_TASKS
) (
    input  logic [$clog2(MAX_TASKS)-1:0] tc,
    input  logic [$clog2(MAX_TASKS)-1:0] last_idx,
    input  logic [$clog2(MAX_TASKS)-1:0] cur_idx,
    input  logic [MAX_TASKS-1:0]         ready_vec,
    input  logic [MAX_TASKS-1:0]         blocked_vec,
    input  logic [MAX_TASKS-1:0]         owed_vec,
    output logic [$clog2(MAX_TASKS)-1:0] next_idx,
    output logic [$clog2(MAX_TASKS)-1:0] last_next,
    output logic [MAX_TASKS-1:0]         owed_next
);

    localparam int IDX_W = $clog2(MAX_TASKS);

    logic [MAX_TASKS-1:0] in_range;
    logic [MAX_TASKS-1:0] owed_m;
    logic [MAX_TASKS-1:0] cand_owed;
    logic [MAX_TASKS-1:0] cand_after;
    logic [MAX_TASKS-1:0] cand_any;
    logic                 all_blocked;
    logic [IDX_W-1:0]     idx_owed;
    logic [IDX_W-1:0]     idx_after;
    logic [IDX_W-1:0]     idx_any;

    // Per-slot masks.
    always_comb
    begin
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            in_range[i] = (IDX_W'(i) < tc);
            owed_m[i]   = owed_vec[i] | (blocked_vec[i] & in_range[i] &
                                         (IDX_W'(i) <= last_idx));
            cand_owed[i]  = owed_m[i] & ready_vec[i] & in_range[i];
            cand_any[i]   = ready_vec[i] & in_range[i];
            cand_after[i] = cand_any[i] & (IDX_W'(i) > last_idx);
        end
        all_blocked = &(~in_range | blocked_vec);
    end

    // Lowest set slot of each candidate mask.
    always_comb
    begin
        idx_owed  = '0;
        idx_after = '0;
        idx_any   = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (cand_owed[i])
            begin
                idx_owed = IDX_W'(i);
            end
            if (cand_after[i])
            begin
                idx_after = IDX_W'(i);
            end
            if (cand_any[i])
            begin
                idx_any = IDX_W'(i);
            end
        end
    end

    // Final choice.
    always_comb
    begin
        next_idx  = cur_idx;
        last_next = last_idx;
        owed_next = owed_m;
        if (all_blocked)
        begin
            next_idx  = tc;
            last_next = tc;
            owed_next = owed_vec;
        end
        else if (|cand_owed)
        begin
            next_idx            = idx_owed;
            last_next           = idx_owed;
            owed_next[idx_owed] = 1'b0;
        end
        else if (|cand_after)
        begin
            next_idx  = idx_after;
            last_next = idx_after;
        end
        else if (|cand_any)
        begin
            next_idx  = idx_any;
            last_next = idx_any;
        end
    end

endmodule

### hdl/rtos_task_scheduler.sv
// A delay, block or wake item passes through S_APPLY and S_SEL before the done
// strobe; a tick also passes through S_TICK, whose sweep over the delay memory
// reads one slot per cycle. One item at a time; busy stays high until the
// result is strobed, and the next item may start in the strobe cycle.
// Reset clears task states, flags, indexes and task_count (to 1); the delay
// memory is not cleared, as an entry is used only after it has been written.
// ---------------------------------------------------------------------------
// rtos_task_scheduler: priority round-robin task scheduler.
// Applies tick, delay, block and wake items, then chooses and switches to
// the next task. Delay counters live in a synchronous memory.
// ---------------------------------------------------------------------------
module rtos_task_scheduler #(
    parameter int MAX_TASKS  = rts_pkg::MAX_TASKS,
    parameter int DELAY_BITS = rts_pkg::DELAY_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          start,
    input  rts_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output rts_pkg::res_t result
);

    localparam int IDX_W = $clog2(MAX_TASKS);

    rts_pkg::state_t       state_reg;
    rts_pkg::req_t         req_reg;
    logic [2:0]            task_count_reg;
    logic [1:0]            stat_reg [MAX_TASKS];
    logic [MAX_TASKS-1:0]  wf_reg;
    logic [MAX_TASKS-1:0]  we_reg;
    logic [MAX_TASKS-1:0]  nz_reg;
    logic [MAX_TASKS-1:0]  owed_reg;
    logic [IDX_W-1:0]      last_reg;
    logic [IDX_W-1:0]      cur_reg;
    logic                  started_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  done_reg;
    rts_pkg::res_t         result_reg;

    logic [IDX_W-1:0]      tc;
    logic                  have_run;
    logic [MAX_TASKS-1:0]  ready_vec;
    logic [MAX_TASKS-1:0]  blocked_vec;
    logic [MAX_TASKS-1:0]  wake_cand;
    logic                  wake_hit;
    logic [IDX_W-1:0]      wake_idx;
    logic [IDX_W-1:0]      sel_next;
    logic [IDX_W-1:0]      sel_last;
    logic [MAX_TASKS-1:0]  sel_owed;
    logic [IDX_W-1:0]      cur_next;
    logic [DELAY_BITS-1:0] dt;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [DELAY_BITS-1:0] mem_wdata;
    logic [DELAY_BITS-1:0] mem_rdata;
    logic                  tick_hit;
    logic                  cfg_write;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & (paddr[2] == rts_pkg::REG_TASK_COUNT);
    assign prdata    = (paddr[2] == rts_pkg::REG_TASK_COUNT) ? {29'b0, task_count_reg} : '0;

    // Number of user tasks, clamped to the slots available.
    assign tc = (32'(task_count_reg) > 32'(MAX_TASKS - 1)) ? IDX_W'(MAX_TASKS - 1)
                                                           : IDX_W'(task_count_reg);

    assign dt = req_reg.delay_ticks[DELAY_BITS-1:0];

    // Status vectors.
    always_comb
    begin
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            ready_vec[i]   = (stat_reg[i] == rts_pkg::ST_READY);
            blocked_vec[i] = (stat_reg[i] == rts_pkg::ST_BLOCK);
            wake_cand[i]   = blocked_vec[i] & (IDX_W'(i) < tc) &
                             (req_reg.queue_side ? we_reg[i] : wf_reg[i]);
        end
    end

    assign have_run = started_reg & (cur_reg < tc) & (stat_reg[cur_reg] == rts_pkg::ST_RUN);

    // First task blocked on the queue side opposite to the one requested.
    always_comb
    begin
        wake_idx = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (wake_cand[i])
            begin
                wake_idx = IDX_W'(i);
            end
        end
    end
    assign wake_hit = |wake_cand;

    // Tick sweep: a blocked task with delay left counts down.
    assign tick_hit = rd_vld_reg & blocked_vec[rd_idx_reg] & nz_reg[rd_idx_reg];

    // Delay memory write port.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg;
        mem_wdata = dt;
        if (state_reg == rts_pkg::S_APPLY && req_reg.req_type == rts_pkg::REQ_DELAY &&
            have_run)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == rts_pkg::S_TICK && tick_hit)
        begin
            mem_we    = 1'b1;
            mem_waddr = rd_idx_reg;
            mem_wdata = mem_rdata - DELAY_BITS'(1);
        end
    end

    rts_delay_mem #(
        .MAX_TASKS (MAX_TASKS),
        .DELAY_BITS(DELAY_BITS)
    ) u_delay_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(cnt_reg),
        .rdata(mem_rdata)
    );

    rts_select #(
        .MAX_TASKS(MAX_TASKS)
    ) u_select (
        .tc         (tc),
        .last_idx   (last_reg),
        .cur_idx    (cur_reg),
        .ready_vec  (ready_vec),
        .blocked_vec(blocked_vec),
        .owed_vec   (owed_reg),
        .next_idx   (sel_next),
        .last_next  (sel_last),
        .owed_next  (sel_owed)
    );

    assign cur_next = started_reg ? sel_next : '0;

    // Sequencer and task state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rts_pkg::S_IDLE;
            req_reg        <= '0;
            task_count_reg <= 3'd1;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                stat_reg[i] <= rts_pkg::ST_READY;
            end
            wf_reg      <= '0;
            we_reg      <= '0;
            nz_reg      <= '0;
            owed_reg    <= '0;
            last_reg    <= '0;
            cur_reg     <= '0;
            started_reg <= 1'b0;
            found_reg   <= 1'b0;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_idx_reg  <= '0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write)
            begin
                task_count_reg <= pwdata[2:0];
            end
            case (state_reg)
                rts_pkg::S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= req;
                        state_reg <= rts_pkg::S_APPLY;
                    end
                end

                rts_pkg::S_APPLY:
                begin
                    found_reg <= 1'b0;
                    cnt_reg   <= '0;
                    state_reg <= rts_pkg::S_SEL;
                    case (req_reg.req_type)
                        rts_pkg::REQ_TICK:
                        begin
                            rd_vld_reg <= 1'b0;
                            state_reg  <= rts_pkg::S_TICK;
                        end
                        rts_pkg::REQ_DELAY:
                        begin
                            if (have_run)
                            begin
                                stat_reg[cur_reg] <= rts_pkg::ST_BLOCK;
                                nz_reg[cur_reg]   <= (dt != '0);
                            end
                        end
                        rts_pkg::REQ_BLOCK:
                        begin
                            if (have_run)
                            begin
                                if (req_reg.queue_side)
                                begin
                                    wf_reg[cur_reg] <= 1'b1;
                                end
                                else
                                begin
                                    we_reg[cur_reg] <= 1'b1;
                                end
                                stat_reg[cur_reg] <= rts_pkg::ST_BLOCK;
                                found_reg         <= 1'b1;
                            end
                        end
                        default:
                        begin
                            if (wake_hit)
                            begin
                                stat_reg[wake_idx] <= rts_pkg::ST_READY;
                                if (req_reg.queue_side)
                                begin
                                    we_reg[wake_idx] <= 1'b0;
                                end
                                else
                                begin
                                    wf_reg[wake_idx] <= 1'b0;
                                end
                                found_reg <= 1'b1;
                            end
                        end
                    endcase
                end

                rts_pkg::S_TICK:
                begin
                    // Issue one read per cycle and finish the slot read last cycle.
                    rd_vld_reg <= (cnt_reg < tc);
                    rd_idx_reg <= cnt_reg;
                    if (cnt_reg < tc)
                    begin
                        cnt_reg <= cnt_reg + IDX_W'(1);
                    end
                    else
                    begin
                        state_reg <= rts_pkg::S_SEL;
                    end
                    if (tick_hit)
                    begin
                        nz_reg[rd_idx_reg] <= (mem_rdata != DELAY_BITS'(1));
                        if (mem_rdata == DELAY_BITS'(1))
                        begin
                            stat_reg[rd_idx_reg] <= rts_pkg::ST_READY;
                        end
                    end
                end

                rts_pkg::S_SEL:
                begin
                    // Context switch and result.
                    if (!started_reg)
                    begin
                        stat_reg[0] <= rts_pkg::ST_RUN;
                        cur_reg     <= '0;
                        started_reg <= 1'b1;
                    end
                    else
                    begin
                        if (!(blocked_vec[cur_reg] &&
                              (nz_reg[cur_reg] || wf_reg[cur_reg] || we_reg[cur_reg])))
                        begin
                            stat_reg[cur_reg] <= rts_pkg::ST_READY;
                        end
                        stat_reg[sel_next] <= rts_pkg::ST_RUN;
                        cur_reg            <= sel_next;
                        last_reg           <= sel_last;
                        owed_reg           <= sel_owed;
                    end
                    result_reg.next_task   <= 3'(cur_next);
                    result_reg.idle_chosen <= (cur_next == tc);
                    result_reg.task_found  <= found_reg;
                    done_reg               <= 1'b1;
                    state_reg              <= rts_pkg::S_IDLE;
                end

                default:
                begin
                    state_reg <= rts_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != rts_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### verif/tb_rtos_task_scheduler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rtos_task_scheduler: self-checking testbench for the task scheduler.
// Drives tick, delay, block and wake items through the start/busy port,
// reconfigures task_count over APB between phases, and compares every
// strobed result with the outcome of a scheduling model held in the bench.
// ---------------------------------------------------------------------------
module tb_rtos_task_scheduler;

    localparam int CYCLE_LIMIT = 400000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [2:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          start = 1'b0;
    rts_pkg::req_t req = '0;
    logic          busy;
    logic          done;
    rts_pkg::res_t result;

    rtos_task_scheduler dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .req(req), .busy(busy), .done(done), .result(result)
    );

    // Scheduler state as the bench sees it.
    logic [1:0]  slot_state [rts_pkg::MAX_TASKS];
    logic [31:0] sleep_left [rts_pkg::MAX_TASKS];
    logic        on_full    [rts_pkg::MAX_TASKS];
    logic        on_empty   [rts_pkg::MAX_TASKS];
    logic        owed       [rts_pkg::MAX_TASKS];
    int          last_pick;
    int          running;
    logic        launched;
    logic [2:0]  user_count;

    rts_pkg::res_t pending_schedule[$];
    int            error_count = 0;
    int            cycle_count = 0;
    bit            no_idle = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Cycle watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[rtos_task_scheduler] ERROR");
            $finish;
        end
    end

    // Pick of the next slot; updates the owed marks and the last index.
    function automatic int pick_next(int tc);
        int blocked_n;
        int idx;
        blocked_n = 0;
        for (int i = 0; i < tc; i++)
            if (slot_state[i] == rts_pkg::ST_BLOCK)
                blocked_n++;
        if (blocked_n == tc)
        begin
            last_pick = tc;
            return tc;
        end
        for (int i = 0; i < tc; i++)
            if (slot_state[i] == rts_pkg::ST_BLOCK && i <= last_pick)
                owed[i] = 1'b1;
        for (int i = 0; i < tc; i++)
        begin
            if (owed[i] && slot_state[i] == rts_pkg::ST_READY)
            begin
                owed[i] = 1'b0;
                last_pick = i;
                return i;
            end
        end
        idx = (last_pick + 1 < tc) ? last_pick + 1 : 0;
        for (int k = 0; k < tc; k++)
        begin
            if (slot_state[idx] == rts_pkg::ST_READY)
            begin
                last_pick = idx;
                return idx;
            end
            idx = (idx + 1 < tc) ? idx + 1 : 0;
        end
        return running;
    endfunction

    // Apply one request to the model and return the expected schedule.
    function automatic rts_pkg::res_t schedule_item(rts_pkg::req_t r);
        int            tc;
        int            nxt;
        logic          found;
        logic          have_run;
        rts_pkg::res_t o;
        tc = user_count;
        found = 1'b0;
        have_run = launched && running < tc && slot_state[running] == rts_pkg::ST_RUN;
        case (r.req_type)
            rts_pkg::REQ_TICK:
            begin
                for (int i = 0; i < tc; i++)
                begin
                    if (slot_state[i] == rts_pkg::ST_BLOCK && sleep_left[i] != 0)
                    begin
                        sleep_left[i] = sleep_left[i] - 32'd1;
                        if (sleep_left[i] == 0)
                            slot_state[i] = rts_pkg::ST_READY;
                    end
                end
            end
            rts_pkg::REQ_DELAY:
            begin
                if (have_run)
                begin
                    slot_state[running] = rts_pkg::ST_BLOCK;
                    sleep_left[running] = r.delay_ticks;
                end
            end
            rts_pkg::REQ_BLOCK:
            begin
                if (have_run)
                begin
                    if (r.queue_side)
                        on_full[running] = 1'b1;
                    else
                        on_empty[running] = 1'b1;
                    slot_state[running] = rts_pkg::ST_BLOCK;
                    found = 1'b1;
                end
            end
            default:
            begin
                for (int i = 0; i < tc; i++)
                begin
                    if (!found && slot_state[i] == rts_pkg::ST_BLOCK &&
                        (r.queue_side ? on_empty[i] : on_full[i]))
                    begin
                        slot_state[i] = rts_pkg::ST_READY;
                        if (r.queue_side)
                            on_empty[i] = 1'b0;
                        else
                            on_full[i] = 1'b0;
                        found = 1'b1;
                    end
                end
            end
        endcase

        if (!launched)
        begin
            running = 0;
            slot_state[0] = rts_pkg::ST_RUN;
            launched = 1'b1;
        end
        else
        begin
            nxt = pick_next(tc);
            if (!(slot_state[running] == rts_pkg::ST_BLOCK &&
                  (sleep_left[running] != 0 || on_full[running] || on_empty[running])))
                slot_state[running] = rts_pkg::ST_READY;
            slot_state[nxt] = rts_pkg::ST_RUN;
            running = nxt;
        end
        o.next_task   = running[2:0];
        o.idle_chosen = (running == tc);
        o.task_found  = found;
        return o;
    endfunction

    // Result checker: each strobed result against the oldest expectation.
    always @(posedge clk)
    begin
        rts_pkg::res_t exp_res;
        if (rst_n && done)
        begin
            if (pending_schedule.size() == 0)
            begin
                $error("result with nothing expected: %p", result);
                error_count++;
            end
            else
            begin
                exp_res = pending_schedule.pop_front();
                if (result.next_task !== exp_res.next_task)
                begin
                    $error("next_task expected %0d got %0d", exp_res.next_task,
                           result.next_task);
                    error_count++;
                end
                if (result.idle_chosen !== exp_res.idle_chosen)
                begin
                    $error("idle_chosen expected %0d got %0d", exp_res.idle_chosen,
                           result.idle_chosen);
                    error_count++;
                end
                if (result.task_found !== exp_res.task_found)
                begin
                    $error("task_found expected %0d got %0d", exp_res.task_found,
                           result.task_found);
                    error_count++;
                end
            end
        end
    end

    // Send one item; start is left high unless a gap follows.
    task automatic send_item(rts_pkg::req_t r);
        int gap;
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        pending_schedule.push_back(schedule_item(r));
        gap = 0;
        if (!no_idle && $urandom_range(99) < 27)
            gap = $urandom_range(1, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic rts_pkg::req_t make_req(logic [1:0] kind, logic [31:0] ticks,
                                               logic side);
        rts_pkg::req_t r;
        r.req_type    = kind;
        r.delay_ticks = ticks;
        r.queue_side  = side;
        return r;
    endfunction

    // Wait for the block to drain, then leave time for a trailing tick sweep.
    task automatic wait_drained();
        @(posedge clk);
        start <= 1'b0;
        while (pending_schedule.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // APB write of task_count, only while the block is idle.
    task automatic set_task_count(logic [2:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= {29'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        user_count = value;
    endtask

    // One random item: mostly well-formed scheduling traffic.
    task automatic send_random();
        logic [1:0]  kind;
        logic [31:0] ticks;
        logic        side;
        int          pick;
        pick  = $urandom_range(99);
        ticks = $urandom;
        side  = 1'($urandom_range(1));
        if (pick < 35)
            kind = rts_pkg::REQ_TICK;
        else if (pick < 60)
        begin
            kind  = rts_pkg::REQ_DELAY;
            ticks = $urandom_range(0, 6);
        end
        else if (pick < 80)
            kind = rts_pkg::REQ_BLOCK;
        else
            kind = rts_pkg::REQ_WAKE;
        send_item(make_req(kind, ticks, side));
    endtask

    // Directed: first item, zero and unit delays, both queue sides, misses.
    task automatic test_directed();
        set_task_count(3'd3);
        send_item(make_req(rts_pkg::REQ_TICK, 32'hFFFF_FFFF, 1'b1));
        send_item(make_req(rts_pkg::REQ_DELAY, 32'd0, 1'b0));
        send_item(make_req(rts_pkg::REQ_DELAY, 32'd1, 1'b0));
        send_item(make_req(rts_pkg::REQ_TICK, 32'd0, 1'b0));
        send_item(make_req(rts_pkg::REQ_BLOCK, 32'hAAAA_AAAA, 1'b1));
        send_item(make_req(rts_pkg::REQ_BLOCK, 32'h5555_5555, 1'b0));
        send_item(make_req(rts_pkg::REQ_BLOCK, 32'd0, 1'b1));
        send_item(make_req(rts_pkg::REQ_DELAY, 32'd3, 1'b0));
        send_item(make_req(rts_pkg::REQ_BLOCK, 32'd0, 1'b0));
        send_item(make_req(rts_pkg::REQ_WAKE, 32'd0, 1'b1));
        send_item(make_req(rts_pkg::REQ_WAKE, 32'd0, 1'b0));
        send_item(make_req(rts_pkg::REQ_WAKE, 32'd0, 1'b0));
        send_item(make_req(rts_pkg::REQ_WAKE, 32'd0, 1'b1));
        send_item(make_req(rts_pkg::REQ_WAKE, 32'd0, 1'b1));
        send_item(make_req(rts_pkg::REQ_DELAY, 32'd2, 1'b1));
        send_item(make_req(rts_pkg::REQ_DELAY, 32'd2, 1'b1));
        send_item(make_req(rts_pkg::REQ_DELAY, 32'd2, 1'b1));
        send_item(make_req(rts_pkg::REQ_DELAY, 32'd2, 1'b1));
        send_item(make_req(rts_pkg::REQ_BLOCK, 32'd0, 1'b1));
        send_item(make_req(rts_pkg::REQ_TICK, 32'd0, 1'b0));
        send_item(make_req(rts_pkg::REQ_TICK, 32'd0, 1'b0));
        send_item(make_req(rts_pkg::REQ_WAKE, 32'd0, 1'b0));
    endtask

    // Random phases over several task counts, extremes included.
    task automatic test_random_phases();
        logic [2:0] counts [7] = '{3'd1, 3'd7, 3'd4, 3'd2, 3'd7, 3'd5, 3'd6};
        for (int p = 0; p < 7; p++)
        begin
            set_task_count(counts[p]);
            no_idle = (p == 2);
            for (int n = 0; n < 95; n++)
                send_random();
        end
        no_idle = 1'b0;
    endtask

    // The sender holds off until every expected result is in.
    task automatic test_drain_pause();
        for (int n = 0; n < 30; n++)
        begin
            send_random();
            if (n % 10 == 9)
                wait_drained();
        end
    endtask

    // Very long delays park tasks for good, so they come last.
    task automatic test_long_delays();
        set_task_count(3'd7);
        send_item(make_req(rts_pkg::REQ_DELAY, 32'hFFFF_FFFF, 1'b0));
        send_item(make_req(rts_pkg::REQ_DELAY, 32'h8000_0000, 1'b1));
        for (int n = 0; n < 30; n++)
            send_random();
    endtask

    initial
    begin
        for (int i = 0; i < rts_pkg::MAX_TASKS; i++)
        begin
            slot_state[i] = rts_pkg::ST_READY;
            sleep_left[i] = '0;
            on_full[i]    = 1'b0;
            on_empty[i]   = 1'b0;
            owed[i]       = 1'b0;
        end
        last_pick  = 0;
        running    = 0;
        launched   = 1'b0;
        user_count = 3'd1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phases();
        test_drain_pause();
        test_long_delays();

        wait_drained();
        if (error_count == 0)
            $display("[rtos_task_scheduler] OK");
        else
            $display("[rtos_task_scheduler] ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/rts_pkg.sv
hdl/rts_delay_mem.sv
hdl/rts_select.sv
hdl/rtos_task_scheduler.sv
verif/tb_rtos_task_scheduler.sv
